### src/gspc_pkg.sv
// ----------------------------------------------------------------------------
// gspc_pkg
// Shared types, constants and curve tables of the gas sensor ppm converter.
// ----------------------------------------------------------------------------
package gspc_pkg;

  // Window lengths and converter full scale.
  localparam int unsigned CAL_WINDOW     = 50;
  localparam int unsigned READ_WINDOW    = 5;
  localparam int unsigned ADC_FULL_SCALE = 1023;

  // Field and datapath widths.
  localparam int unsigned ADC_W   = 10;
  localparam int unsigned FS_W    = 12;
  localparam int unsigned PPM_W   = 15;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned DIV_W   = 52;
  localparam int unsigned DVS_W   = 32;
  localparam int unsigned L10_W   = 24;
  localparam int unsigned PADDR_W = 4;

  // Fixed-point constants, Q16.16 unless noted.
  localparam logic signed [31:0] LOG10_2_Q32 = 32'sd1292913987;
  localparam logic signed [31:0] CURVE_A     = 32'sd150733;
  localparam logic [31:0]        REF_RESET   = 32'd655360;
  localparam logic [PPM_W-1:0]   PPM_MAX     = '1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOAD_RES  = 2'd0;
  localparam logic [1:0] REG_CLEAN_AIR = 2'd1;
  localparam logic [1:0] REG_SMOKE_THR = 2'd2;

  // Gas indexes.
  localparam logic [1:0] GAS_LPG = 2'd0;
  localparam logic [1:0] GAS_CO  = 2'd1;
  localparam logic [1:0] GAS_SMK = 2'd2;

  // Fan command codes.
  localparam logic [1:0] FAN_OFF     = 2'd0;
  localparam logic [1:0] FAN_ON      = 2'd1;
  localparam logic [1:0] FAN_UNKNOWN = 2'd2;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Curve offset b of each gas.
  function automatic logic signed [L10_W-1:0] curve_b(input logic [1:0] gas);
    logic signed [L10_W-1:0] b;
    unique case (gas)
      GAS_LPG: b = 24'sd13763;
      GAS_CO:  b = 24'sd47186;
      GAS_SMK: b = 24'sd34734;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Magnitude of the (negative) curve slope m of each gas.
  function automatic logic [15:0] curve_m_mag(input logic [1:0] gas);
    logic [15:0] m;
    unique case (gas)
      GAS_LPG: m = 16'd30802;
      GAS_CO:  m = 16'd22282;
      GAS_SMK: m = 16'd28836;
      default: m = 16'd1;
    endcase
    return m;
  endfunction

endpackage

### src/gspc_if.sv
// ----------------------------------------------------------------------------
// gspc_in_if / gspc_out_if
// Valid/ready channels carrying sample items and result items.
// ----------------------------------------------------------------------------
interface gspc_in_if;
  import gspc_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, command, adc_sample, input ready);
  modport sink (input valid, command, adc_sample, output ready);
endinterface

interface gspc_out_if;
  import gspc_pkg::*;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [31:0]      reference_resistance;
  logic [PPM_W-1:0] lpg_ppm;
  logic [PPM_W-1:0] co_ppm;
  logic [PPM_W-1:0] smoke_ppm;
  logic             fan_on;
  logic             fan_changed;
  logic             zero_sample_error;

  modport source (output valid, result_kind, reference_resistance, lpg_ppm, co_ppm,
                  smoke_ppm, fan_on, fan_changed, zero_sample_error, input ready);
  modport sink (input valid, result_kind, reference_resistance, lpg_ppm, co_ppm,
                smoke_ppm, fan_on, fan_changed, zero_sample_error, output ready);
endinterface

### src/gspc_div.sv
// ----------------------------------------------------------------------------
// gspc_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module gspc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gspc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [gspc_pkg::DVS_W-1:0]  divisor_i,
  output gspc_pkg::unit_stat_t        stat_o,
  output logic [gspc_pkg::DIV_W-1:0]  quotient_o
);
  import gspc_pkg::*;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q + 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

### src/gspc_log.sv
// ----------------------------------------------------------------------------
// gspc_log
// Iterative log10 of a nonzero unsigned Q16.16 value: leading-one search by
// single-bit shifts, sixteen squarings of a Q1.31 mantissa, then a scale.
// ----------------------------------------------------------------------------
module gspc_log (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [gspc_pkg::DIV_W-1:0]         x_i,
  output gspc_pkg::unit_stat_t               stat_o,
  output logic signed [gspc_pkg::L10_W-1:0]  log_o
);
  import gspc_pkg::*;

  localparam logic [2:0] PH_NORM  = 3'd0;
  localparam logic [2:0] PH_MUL   = 3'd1;
  localparam logic [2:0] PH_RED   = 3'd2;
  localparam logic [2:0] PH_SCALE = 3'd3;
  localparam logic [2:0] PH_OUT   = 3'd4;

  logic                busy_q, done_q;
  logic [2:0]          ph_q;
  logic [CNT_W-1:0]    pos_q;
  logic [3:0]          bit_q;
  logic [DIV_W-1:0]    n_q;
  logic [31:0]         m_q;
  logic [63:0]         prod_q;
  logic [15:0]         frac_q;
  logic signed [54:0]  lp_q;
  logic signed [L10_W-1:0] res_q;
  logic [32:0]         sq;
  logic signed [22:0]  v;
  logic [6:0]          ipart;

  always_comb begin
    sq    = prod_q[63:31];
    ipart = {1'b0, pos_q} - 7'd16;
    v     = $signed({ipart, frac_q});
  end

  // Phase control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PH_NORM;
      pos_q  <= '0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      ph_q   <= PH_NORM;
      pos_q  <= CNT_W'(DIV_W - 1);
      bit_q  <= 4'd15;
    end else if (busy_q) begin
      unique case (ph_q)
        PH_NORM: begin
          if (n_q[DIV_W-1] || pos_q == '0) begin
            ph_q <= PH_MUL;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        PH_MUL: ph_q <= PH_RED;
        PH_RED: begin
          if (bit_q == '0) begin
            ph_q <= PH_SCALE;
          end else begin
            bit_q <= bit_q - 1'b1;
            ph_q  <= PH_MUL;
          end
        end
        PH_SCALE: ph_q <= PH_OUT;
        PH_OUT: begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        default: ph_q <= PH_NORM;
      endcase
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: normalize, square, reduce, scale by log10(2).
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= x_i;
      frac_q <= '0;
    end else if (busy_q) begin
      unique case (ph_q)
        PH_NORM: begin
          if (n_q[DIV_W-1] || pos_q == '0) begin
            m_q <= n_q[DIV_W-1 -: 32];
          end else begin
            n_q <= {n_q[DIV_W-2:0], 1'b0};
          end
        end
        PH_MUL: prod_q <= m_q * m_q;
        PH_RED: begin
          if (sq[32]) begin
            m_q           <= sq[32:1];
            frac_q[bit_q] <= 1'b1;
          end else begin
            m_q <= sq[31:0];
          end
        end
        PH_SCALE: lp_q <= v * LOG10_2_Q32;
        PH_OUT:   res_q <= {lp_q[54], lp_q[54:32]};
        default: ;
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign log_o       = res_q;

endmodule

### src/gas_sensor_ppm_converter_unit.sv
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_unit
// Turns ADC samples into sensor resistance, averages windows, keeps the
// clean-air reference and reports LPG, CO and smoke ppm with a fan command.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on sample_i (command, adc_sample); a result item leaves on
// result_o only when a window closes: 50 calibration samples or 5
// measurement samples. A change of command restarts the window.
// Registers (load resistor, clean-air factor, smoke threshold) are to be
// written over the APB port only while the block is idle; the block itself
// does not enforce this. pready is always high. One shared 52-step divider
// and one iterative log10 unit do all the work. A sample that does not close
// a window passes through the divider before the next item is accepted; a
// zero or full-scale reading needs no division. A calibration close adds two
// divisions. A measurement close adds two divisions, one log10 and, per gas,
// a division and a 15-step binary search of log10 evaluations.
// sample_i.ready is high only between items. A finished result sits in an
// output register; the next item is accepted meanwhile, but its own result
// waits until the receiver has taken the previous one.
// Reset clears the window, sets the reference to 10.0 kilo-ohms, the fan
// state to unknown and the registers to their defaults.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gspc_in_if.sink                         sample_i,
  gspc_out_if.source                      result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gspc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gspc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SDIV = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_REF  = 4'd4;
  localparam logic [3:0] S_RAT  = 4'd5;
  localparam logic [3:0] S_LRAT = 4'd6;
  localparam logic [3:0] S_CURV = 4'd7;
  localparam logic [3:0] S_CDIV = 4'd8;
  localparam logic [3:0] S_SRCH = 4'd9;
  localparam logic [3:0] S_SLOG = 4'd10;
  localparam logic [3:0] S_FAN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration registers.
  logic [7:0]       rl_q;
  logic [15:0]      caf_q;
  logic [PPM_W-1:0] thr_q;
  logic             cfg_wr;

  // Sequencer state.
  logic [3:0]       state_q, state_d;
  logic             mode_q, mode_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             zero_q, zero_d;
  logic [31:0]      ref_q, ref_d;
  logic [1:0]       fan_q, fan_d;
  logic             cmd_q, cmd_d;
  logic [31:0]      res_q, res_d;
  logic             zflag_q, zflag_d;
  logic signed [L10_W-1:0] l10_q, l10_d;
  logic [1:0]       gas_q, gas_d;
  logic             dneg_q, dneg_d;
  logic signed [31:0] e_q, e_d;
  logic [PPM_W-1:0] p_q, p_d;
  logic [3:0]       bit_q, bit_d;
  logic [PPM_W-1:0] ppm_q [0:2];
  logic [PPM_W-1:0] ppm_d [0:2];
  logic             fon_q, fon_d;
  logic             chg_q, chg_d;

  // Output register.
  logic             ov_q;
  logic             out_load;
  logic             okind_q, ofon_q, ochg_q, ozero_q;
  logic [31:0]      oref_q;
  logic [PPM_W-1:0] olpg_q, oco_q, osmk_q;

  // Shared units.
  logic             div_start, log_start;
  logic [DIV_W-1:0] div_dividend, div_quo, log_x;
  logic [DVS_W-1:0] div_divisor;
  unit_stat_t       div_stat, log_stat;
  logic signed [L10_W-1:0] log_res;

  // Helpers.
  logic             accept;
  logic [CNT_W-1:0] window, cnt_next;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_new;
  logic signed [L10_W-1:0] dval;
  logic [L10_W-1:0] dmag;
  logic [15:0]      caf_eff;
  logic [PPM_W-1:0] cand;
  logic signed [31:0] e_new, log_ext;

  gspc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  gspc_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .stat_o  (log_stat),
    .log_o   (log_res)
  );

  // APB register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q  <= 8'd5;
      caf_q <= 16'd2516;
      thr_q <= 15'd100;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOAD_RES:  rl_q  <= pwdata[7:0];
        REG_CLEAN_AIR: caf_q <= pwdata[15:0];
        REG_SMOKE_THR: thr_q <= pwdata[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOAD_RES:  prdata = {24'd0, rl_q};
      REG_CLEAN_AIR: prdata = {16'd0, caf_q};
      REG_SMOKE_THR: prdata = {17'd0, thr_q};
      default:       prdata = '0;
    endcase
  end

  // Handshake on the input side.
  assign sample_i.ready = (state_q == S_IDLE);
  assign accept         = sample_i.valid && (state_q == S_IDLE);
  assign out_load       = (state_q == S_OUT) && (!ov_q || result_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    count_d = count_q;
    sum_d   = sum_q;
    zero_d  = zero_q;
    ref_d   = ref_q;
    fan_d   = fan_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    zflag_d = zflag_q;
    l10_d   = l10_q;
    gas_d   = gas_q;
    dneg_d  = dneg_q;
    e_d     = e_q;
    p_d     = p_q;
    bit_d   = bit_q;
    ppm_d   = ppm_q;
    fon_d   = fon_q;
    chg_d   = chg_q;

    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    log_start    = 1'b0;
    log_x        = '0;

    window   = cmd_q ? CNT_W'(READ_WINDOW) : CNT_W'(CAL_WINDOW);
    cnt_next = count_q + 1'b1;
    sum_wide = {1'b0, sum_q} + {5'd0, res_q};
    sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    dval     = l10_q - curve_b(gas_q);
    dmag     = dval[L10_W-1] ? L10_W'(-dval) : L10_W'(dval);
    caf_eff  = (caf_q == '0) ? 16'd1 : caf_q;
    cand     = p_q | (PPM_W'(1) << bit_q);
    e_new    = dneg_q ? CURVE_A + $signed(div_quo[31:0]) : CURVE_A - $signed(div_quo[31:0]);
    log_ext  = 32'(log_res);

    unique case (state_q)
      // Accept a sample; a zero or full-scale reading needs no division.
      S_IDLE: begin
        if (accept) begin
          cmd_d = sample_i.command;
          if (sample_i.command != mode_q) begin
            sum_d   = '0;
            count_d = '0;
            zero_d  = 1'b0;
            mode_d  = sample_i.command;
          end
          if (sample_i.adc_sample == '0) begin
            zero_d  = 1'b1;
            res_d   = '1;
            state_d = S_ACC;
          end else if (FS_W'(sample_i.adc_sample) >= FS_W'(ADC_FULL_SCALE)) begin
            res_d   = '0;
            state_d = S_ACC;
          end else begin
            div_start    = 1'b1;
            div_dividend = {{(DIV_W-36){1'b0}},
                            20'(rl_q) * 20'(FS_W'(ADC_FULL_SCALE) - FS_W'(sample_i.adc_sample)),
                            16'd0};
            div_divisor  = DVS_W'(sample_i.adc_sample);
            state_d      = S_SDIV;
          end
        end
      end
      // Sample resistance, capped at 32 bits.
      S_SDIV: begin
        if (div_stat.done) begin
          res_d   = (div_quo[DIV_W-1:32] != '0) ? '1 : div_quo[31:0];
          state_d = S_ACC;
        end
      end
      // Add to the window; a full window starts the average.
      S_ACC: begin
        if (cnt_next < window) begin
          sum_d   = sum_new;
          count_d = cnt_next;
          state_d = S_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(sum_new);
          div_divisor  = DVS_W'(window);
          zflag_d      = zero_q;
          sum_d        = '0;
          count_d      = '0;
          zero_d       = 1'b0;
          state_d      = S_AVG;
        end
      end
      // Average ready: calibrate or form the ratio; a zero reference skips to the fan.
      S_AVG: begin
        if (div_stat.done) begin
          ppm_d[GAS_LPG] = '0;
          ppm_d[GAS_CO]  = '0;
          ppm_d[GAS_SMK] = '0;
          if (!cmd_q) begin
            div_start    = 1'b1;
            div_dividend = {8'd0, div_quo[SUM_W-1:0], 8'd0};
            div_divisor  = DVS_W'(caf_eff);
            state_d      = S_REF;
          end else if (ref_q == '0) begin
            state_d = S_FAN;
          end else begin
            div_start    = 1'b1;
            div_dividend = {div_quo[SUM_W-1:0], 16'd0};
            div_divisor  = ref_q;
            state_d      = S_RAT;
          end
        end
      end
      // New reference resistance.
      S_REF: begin
        if (div_stat.done) begin
          ref_d   = (div_quo[DIV_W-1:32] != '0) ? '1 : div_quo[31:0];
          fon_d   = (fan_q == FAN_ON);
          chg_d   = 1'b0;
          state_d = S_OUT;
        end
      end
      // Ratio ready: a zero ratio saturates all gases.
      S_RAT: begin
        if (div_stat.done) begin
          if (div_quo == '0) begin
            ppm_d[GAS_LPG] = PPM_MAX;
            ppm_d[GAS_CO]  = PPM_MAX;
            ppm_d[GAS_SMK] = PPM_MAX;
            state_d = S_FAN;
          end else begin
            log_start = 1'b1;
            log_x     = div_quo;
            state_d   = S_LRAT;
          end
        end
      end
      S_LRAT: begin
        if (log_stat.done) begin
          l10_d   = log_res;
          gas_d   = GAS_LPG;
          state_d = S_CURV;
        end
      end
      // Exponent of the current gas curve.
      S_CURV: begin
        div_start    = 1'b1;
        div_dividend = {12'd0, dmag, 16'd0};
        div_divisor  = DVS_W'(curve_m_mag(gas_q));
        dneg_d       = dval[L10_W-1];
        state_d      = S_CDIV;
      end
      S_CDIV: begin
        if (div_stat.done) begin
          e_d   = e_new;
          p_d   = '0;
          bit_d = 4'd14;
          if (e_new < 0) begin
            ppm_d[gas_q] = '0;
            if (gas_q == GAS_SMK) begin
              state_d = S_FAN;
            end else begin
              gas_d   = gas_q + 1'b1;
              state_d = S_CURV;
            end
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      // Binary search for the largest ppm whose log10 fits the exponent.
      S_SRCH: begin
        log_start = 1'b1;
        log_x     = DIV_W'({cand, 16'd0});
        state_d   = S_SLOG;
      end
      S_SLOG: begin
        if (log_stat.done) begin
          if (log_ext <= e_q) begin
            p_d = cand;
          end
          if (bit_q == '0) begin
            ppm_d[gas_q] = (log_ext <= e_q) ? cand : p_q;
            if (gas_q == GAS_SMK) begin
              state_d = S_FAN;
            end else begin
              gas_d   = gas_q + 1'b1;
              state_d = S_CURV;
            end
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = S_SRCH;
          end
        end
      end
      // Fan decision from smoke.
      S_FAN: begin
        fon_d   = ppm_q[GAS_SMK] > thr_q;
        chg_d   = {1'b0, fon_d} != fan_q;
        fan_d   = fon_d ? FAN_ON : FAN_OFF;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
      zero_q  <= 1'b0;
      ref_q   <= REF_RESET;
      fan_q   <= FAN_UNKNOWN;
      gas_q   <= GAS_LPG;
      bit_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      zero_q  <= zero_d;
      ref_q   <= ref_d;
      fan_q   <= fan_d;
      gas_q   <= gas_d;
      bit_q   <= bit_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    zflag_q <= zflag_d;
    l10_q   <= l10_d;
    dneg_q  <= dneg_d;
    e_q     <= e_d;
    p_q     <= p_d;
    ppm_q   <= ppm_d;
    fon_q   <= fon_d;
    chg_q   <= chg_d;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      okind_q <= cmd_q;
      oref_q  <= ref_q;
      olpg_q  <= ppm_q[GAS_LPG];
      oco_q   <= ppm_q[GAS_CO];
      osmk_q  <= ppm_q[GAS_SMK];
      ofon_q  <= fon_q;
      ochg_q  <= chg_q;
      ozero_q <= zflag_q;
    end
  end

  assign result_o.valid                = ov_q;
  assign result_o.result_kind          = okind_q;
  assign result_o.reference_resistance = oref_q;
  assign result_o.lpg_ppm              = olpg_q;
  assign result_o.co_ppm               = oco_q;
  assign result_o.smoke_ppm            = osmk_q;
  assign result_o.fan_on               = ofon_q;
  assign result_o.fan_changed          = ochg_q;
  assign result_o.zero_sample_error    = ozero_q;

  // An accepted item always leaves the idle state at once.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !sample_i.ready)
    else $error("input still ready after an accepted item");

  // The window count never reaches the window length of its mode.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q ? CNT_W'(READ_WINDOW) : CNT_W'(CAL_WINDOW)) > count_q)
    else $error("window count overran its window");

  // The shared divider is never restarted while it iterates.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The log unit is never restarted while it iterates.
  a_log_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_start |-> !log_stat.busy)
    else $error("log unit started while busy");

endmodule
